>>> src/fbla_pkg.sv
// ----------------------------------------------------------------------------
// fbla_pkg
// shared types and codes for the free block list allocator
// ----------------------------------------------------------------------------
package fbla_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int OFFSET_W            = 32;
    localparam int SIZE_W              = 16;
    localparam int FREE_ENTRIES_W      = 7;

    // fit policy codes
    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_BEST  = 2'd1;
    localparam logic [1:0] POLICY_WORST = 2'd2;
    localparam logic [1:0] POLICY_NEXT  = 2'd3;

    // response status codes
    localparam logic [1:0] ST_GRANTED  = 2'd0;
    localparam logic [1:0] ST_NO_MATCH = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // request type codes
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [OFFSET_W-1:0] block_offset;
        logic [SIZE_W-1:0]   block_size;
    } req_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [OFFSET_W-1:0]       grant_offset;
        logic [FREE_ENTRIES_W-1:0] free_entries;
    } rsp_t;

    // one table entry
    typedef struct packed {
        logic [SIZE_W-1:0]   size;
        logic [OFFSET_W-1:0] offset;
    } entry_t;

endpackage

>>> src/free_block_list_allocator_core.sv
// ----------------------------------------------------------------------------
// free_block_list_allocator_core
// free block table with first, best, worst and next fit policies
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid/req_ready/req): one word per request, either a
//   release of a block (offset, size) or an allocate of an exact size
//   rsp channel (rsp_valid/rsp_ready/rsp): exactly one word per request with
//   status, granted offset and the number of free blocks left in the table
//   cfg_we/cfg_data: writes the fit policy; user must do it only while the block is idle (unenforced)
// request flow
//   one request at a time; the result word shows after any scan and entry
//   moves, and req_ready returns in the same cycle as the result word;
//   under next fit a scan may wrap past the rover before it closes a slot
//   near the bottom; the pace is set by the single table read port: one
//   entry scanned per cycle, then one entry moved per cycle to open or
//   close a slot
// stalls
//   the finished word sits in an output register; the next request is taken
//   while it waits, and a later result waits in the done state until the
//   output register frees up
// reset
//   table empties (entry count and rover to zero), policy back to first fit;
//   table storage itself is not cleared, entries past the count are never read
// ----------------------------------------------------------------------------
module free_block_list_allocator_core
    import fbla_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data
);

    // index width and count width (count reaches TABLE_DEPTH)
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_INS_SHIFT,
        S_INS_WRITE,
        S_ALC_SHIFT,
        S_DONE
    } state_t;

    state_t                state_reg,    state_next;
    req_t                  req_reg,      req_next;
    logic [1:0]            policy_reg,   policy_next;
    logic [CW-1:0]         count_reg,    count_next;
    logic [IW-1:0]         rover_reg,    rover_next;
    // read pointer, and the index whose data is in the ram output register
    logic [CW-1:0]         rd_ptr_reg,   rd_ptr_next;
    logic [CW-1:0]         chk_ptr_reg,  chk_ptr_next;
    logic                  rd_vld_reg,   rd_vld_next;
    // scan bookkeeping: reads issued and entries checked
    logic [CW-1:0]         iss_cnt_reg,  iss_cnt_next;
    logic [CW-1:0]         chk_cnt_reg,  chk_cnt_next;
    logic                  stop_reg,     stop_next;
    logic [CW-1:0]         pos_reg,      pos_next;
    logic [1:0]            status_reg,   status_next;
    logic [OFFSET_W-1:0]   grant_reg,    grant_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg,      rsp_next;

    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    entry_t                mem_wdata;
    entry_t                mem_rdata;

    logic                  is_release;
    logic                  sorted;
    logic                  hit;
    logic [CW-1:0]         rd_ptr_inc;
    logic [CW-1:0]         chk_ptr_inc;

    fbla_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_ptr_reg[IW-1:0]),
        .rdata (mem_rdata)
    );

    assign is_release  = (req_reg.req_type == REQ_RELEASE);
    assign sorted      = (policy_reg == POLICY_BEST) || (policy_reg == POLICY_WORST);
    assign rd_ptr_inc  = rd_ptr_reg + CW'(1);
    assign chk_ptr_inc = chk_ptr_reg + CW'(1);

    // scan match: insert point for sorted release, exact size for allocate
    always_comb
    begin
        if (is_release)
        begin
            if (policy_reg == POLICY_BEST)
            begin
                hit = (mem_rdata.size > req_reg.block_size);
            end
            else
            begin
                hit = (mem_rdata.size < req_reg.block_size);
            end
        end
        else
        begin
            hit = (mem_rdata.size == req_reg.block_size);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        policy_next    = policy_reg;
        count_next     = count_reg;
        rover_next     = rover_reg;
        rd_ptr_next    = rd_ptr_reg;
        chk_ptr_next   = chk_ptr_reg;
        rd_vld_next    = 1'b0;
        iss_cnt_next   = iss_cnt_reg;
        chk_cnt_next   = chk_cnt_reg;
        stop_next      = stop_reg;
        pos_next       = pos_reg;
        status_next    = status_reg;
        grant_next     = grant_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        req_ready      = (state_reg == S_IDLE);

        if (cfg_we)
        begin
            policy_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                grant_next   = '0;
                iss_cnt_next = '0;
                chk_cnt_next = '0;
                rd_ptr_next  = '0;
                if (is_release)
                begin
                    if (count_reg == CW'(TABLE_DEPTH))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else if (sorted && (count_reg != '0))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        // append at the end, nothing to move
                        pos_next   = count_reg;
                        state_next = S_INS_WRITE;
                    end
                end
                else
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_NO_MATCH;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        if ((policy_reg == POLICY_NEXT) && (CW'(rover_reg) < count_reg))
                        begin
                            rd_ptr_next = CW'(rover_reg);
                        end
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle, wrapping at the entry count
                if (iss_cnt_reg != count_reg)
                begin
                    rd_ptr_next  = (rd_ptr_inc == count_reg) ? '0 : rd_ptr_inc;
                    iss_cnt_next = iss_cnt_reg + CW'(1);
                    chk_ptr_next = rd_ptr_reg;
                    rd_vld_next  = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (hit)
                    begin
                        pos_next    = chk_ptr_reg;
                        rd_vld_next = 1'b0;
                        stop_next   = 1'b0;
                        if (is_release)
                        begin
                            // move entries pos..count-1 up by one, top first
                            rd_ptr_next = count_reg - CW'(1);
                            state_next  = S_INS_SHIFT;
                        end
                        else
                        begin
                            grant_next = mem_rdata.offset;
                            if (policy_reg == POLICY_NEXT)
                            begin
                                rover_next = (chk_ptr_inc == count_reg)
                                           ? '0 : chk_ptr_reg[IW-1:0];
                            end
                            rd_ptr_next = chk_ptr_inc;
                            state_next  = S_ALC_SHIFT;
                        end
                    end
                    else
                    begin
                        chk_cnt_next = chk_cnt_reg + CW'(1);
                        if ((chk_cnt_reg + CW'(1)) == count_reg)
                        begin
                            rd_vld_next = 1'b0;
                            if (is_release)
                            begin
                                pos_next   = count_reg;
                                state_next = S_INS_WRITE;
                            end
                            else
                            begin
                                status_next = ST_NO_MATCH;
                                state_next  = S_DONE;
                            end
                        end
                    end
                end
            end

            S_INS_SHIFT:
            begin
                if (!stop_reg)
                begin
                    chk_ptr_next = rd_ptr_reg;
                    rd_vld_next  = 1'b1;
                    if (rd_ptr_reg == pos_reg)
                    begin
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg - CW'(1);
                    end
                end
                if (rd_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = chk_ptr_inc[IW-1:0];
                    mem_wdata = mem_rdata;
                    if (chk_ptr_reg == pos_reg)
                    begin
                        rd_vld_next = 1'b0;
                        state_next  = S_INS_WRITE;
                    end
                end
            end

            S_INS_WRITE:
            begin
                mem_we           = 1'b1;
                mem_waddr        = pos_reg[IW-1:0];
                mem_wdata.size   = req_reg.block_size;
                mem_wdata.offset = req_reg.block_offset;
                count_next       = count_reg + CW'(1);
                status_next      = ST_RELEASED;
                state_next       = S_DONE;
            end

            S_ALC_SHIFT:
            begin
                // move entries above the granted one down by one, bottom first
                if (rd_ptr_reg != count_reg)
                begin
                    chk_ptr_next = rd_ptr_reg;
                    rd_vld_next  = 1'b1;
                    rd_ptr_next  = rd_ptr_inc;
                end
                if (rd_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = IW'(chk_ptr_reg - CW'(1));
                    mem_wdata = mem_rdata;
                end
                if ((rd_ptr_reg == count_reg) && !rd_vld_reg)
                begin
                    count_next  = count_reg - CW'(1);
                    status_next = ST_GRANTED;
                    state_next  = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.status       = status_reg;
                    rsp_next.grant_offset = grant_reg;
                    rsp_next.free_entries = FREE_ENTRIES_W'(count_reg);
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= POLICY_FIRST;
            count_reg     <= '0;
            rover_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            stop_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            count_reg     <= count_next;
            rover_reg     <= rover_next;
            rd_vld_reg    <= rd_vld_next;
            stop_reg      <= stop_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        rd_ptr_reg  <= rd_ptr_next;
        chk_ptr_reg <= chk_ptr_next;
        iss_cnt_reg <= iss_cnt_next;
        chk_cnt_reg <= chk_cnt_next;
        pos_reg     <= pos_next;
        status_reg  <= status_next;
        grant_reg   <= grant_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> src/fbla_ram.sv
// ----------------------------------------------------------------------------
// fbla_ram
// free block table storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module fbla_ram
    import fbla_pkg::*;
#(
    parameter int DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/fbla_checker.sv
// ----------------------------------------------------------------------------
// fbla_checker
// port level checks for the free block list allocator
// ----------------------------------------------------------------------------
module fbla_checker
    import fbla_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input rsp_t       rsp
);

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response word changed while stalled");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while busy");

    // only a grant carries an offset
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_GRANTED) |-> rsp.grant_offset == '0)
        else $error("offset on a non-grant response");

    // table full reports a full count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL)
        |-> rsp.free_entries == FREE_ENTRIES_W'(TABLE_DEPTH))
        else $error("table full with a short count");

    // no response word rises right after a request is accepted
    a_no_early_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("response right after request accept");

endmodule

bind free_block_list_allocator_core fbla_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_fbla_checker (.*);
